[rtl/core/isc_pkg.sv]
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, codes and constants for the i2c address scan sequencer.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned TableDepth   = 16;
  localparam int unsigned ProgressStep = 8;

  localparam logic [15:0] PowerDelayRst  = 16'd100;
  localparam logic [15:0] SettleDelayRst = 16'd20;
  localparam logic [6:0]  FirstAddrRst   = 7'h03;
  localparam logic [6:0]  LastAddrRst    = 7'h77;

  localparam logic [7:0] ProbeAck  = 8'd0;
  localparam logic [7:0] ProbeNack = 8'd2;
  localparam logic [7:0] CountMax  = 8'hff;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_START   = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_RESET   = 3'd3,
    KIND_CONSUME = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_POWERING = 3'd1,
    PH_SETTLING = 3'd2,
    PH_SCANNING = 3'd3,
    PH_SCANNED  = 3'd4,
    PH_ERROR    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    REG_POWER_DELAY  = 2'd0,
    REG_SETTLE_DELAY = 2'd1,
    REG_FIRST_ADDR   = 2'd2,
    REG_LAST_ADDR    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic        bus_ready;
    logic [7:0]  probe_status;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  scan_state;
    logic        accepted;
    logic [6:0]  scan_address;
    logic [4:0]  device_count;
    logic [7:0]  overflow_count;
    logic [7:0]  error_count;
    logic        changed;
    logic        power_on;
    logic        bus_release;
    logic        found_valid;
    logic [6:0]  found_address;
    logic [31:0] last_scan_ms;
  } out_word_t;

  typedef struct packed {
    logic [15:0] power_delay_ms;
    logic [15:0] settle_delay_ms;
    logic [6:0]  first_address;
    logic [6:0]  last_address;
  } cfg_t;

endpackage

[rtl/core/isc_in_stage.sv]
// ----------------------------------------------------------------------------
// isc_in_stage
// Input register: holds one accepted word until the step logic takes it.
// ----------------------------------------------------------------------------
module isc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  isc_pkg::in_word_t in_data_i,
  input  logic              take_i,
  output logic              vld_o,
  output isc_pkg::in_word_t data_o
);

  logic              vld_d, vld_q;
  isc_pkg::in_word_t data_q;
  logic              accept;

  // stall only while a held word cannot move on this cycle
  assign in_stall_o = vld_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

[rtl/core/isc_step.sv]
// ----------------------------------------------------------------------------
// isc_step
// Sequencer state and the single-pass update for one input word.
// ----------------------------------------------------------------------------
module isc_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  isc_pkg::in_word_t  item_i,
  input  isc_pkg::cfg_t      cfg_i,
  output isc_pkg::out_word_t res_o
);

  isc_pkg::phase_e phase_d, phase_q;
  logic [31:0]     deadline_d, deadline_q;
  logic [6:0]      addr_d, addr_q;
  logic [4:0]      found_d, found_q;
  logic [7:0]      ovf_d, ovf_q;
  logic [7:0]      err_d, err_q;
  logic            changed_d, changed_q;
  logic [31:0]     finish_d, finish_q;

  logic            busy;
  logic            met;
  logic [31:0]     since;
  logic [6:0]      span;
  logic            accepted, pwr, release_req, fvalid, changed_out;
  logic [6:0]      faddr;

  assign busy  = (phase_q == isc_pkg::PH_POWERING) || (phase_q == isc_pkg::PH_SETTLING) ||
                 (phase_q == isc_pkg::PH_SCANNING);
  // wrap-safe deadline compare
  assign since = item_i.now_ms - deadline_q;
  assign met   = !since[31];
  assign span  = addr_q + 7'd1 - cfg_i.first_address;

  always_comb begin
    phase_d     = phase_q;
    deadline_d  = deadline_q;
    addr_d      = addr_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    err_d       = err_q;
    changed_d   = changed_q;
    finish_d    = finish_q;
    accepted    = 1'b0;
    pwr         = 1'b0;
    release_req = 1'b0;
    fvalid      = 1'b0;
    faddr       = 7'd0;
    unique case (isc_pkg::kind_e'(item_i.kind))
      isc_pkg::KIND_TICK: begin
        if (phase_q == isc_pkg::PH_POWERING && met) begin
          if (!item_i.bus_ready) begin
            release_req = 1'b1;
            phase_d     = isc_pkg::PH_ERROR;
          end else begin
            deadline_d = item_i.now_ms + {16'd0, cfg_i.settle_delay_ms};
            phase_d    = isc_pkg::PH_SETTLING;
          end
          changed_d = 1'b1;
        end else if (phase_q == isc_pkg::PH_SETTLING && met) begin
          phase_d   = isc_pkg::PH_SCANNING;
          changed_d = 1'b1;
        end else if (phase_q == isc_pkg::PH_SCANNING) begin
          if (item_i.probe_status == isc_pkg::ProbeAck) begin
            if (found_q < 5'(isc_pkg::TableDepth)) begin
              found_d = found_q + 5'd1;
              fvalid  = 1'b1;
              faddr   = addr_q;
            end else if (ovf_q != isc_pkg::CountMax) begin
              ovf_d = ovf_q + 8'd1;
            end
            changed_d = 1'b1;
          end else if (item_i.probe_status != isc_pkg::ProbeNack) begin
            if (err_q != isc_pkg::CountMax) begin
              err_d = err_q + 8'd1;
            end
            changed_d = 1'b1;
          end
          if (addr_q >= cfg_i.last_address) begin
            release_req = 1'b1;
            finish_d    = item_i.now_ms;
            phase_d     = isc_pkg::PH_SCANNED;
            changed_d   = 1'b1;
          end else begin
            addr_d = addr_q + 7'd1;
            // progress mark every few addresses
            if ((span % 7'(isc_pkg::ProgressStep)) == 7'd0) begin
              changed_d = 1'b1;
            end
          end
        end
      end
      isc_pkg::KIND_START: begin
        if (!busy) begin
          found_d    = 5'd0;
          ovf_d      = 8'd0;
          err_d      = 8'd0;
          addr_d     = cfg_i.first_address;
          pwr        = 1'b1;
          deadline_d = item_i.now_ms + {16'd0, cfg_i.power_delay_ms};
          phase_d    = isc_pkg::PH_POWERING;
          changed_d  = 1'b1;
          accepted   = 1'b1;
        end
      end
      isc_pkg::KIND_STOP, isc_pkg::KIND_RESET: begin
        release_req = busy;
        phase_d     = isc_pkg::PH_IDLE;
        changed_d   = 1'b1;
        if (item_i.kind == isc_pkg::KIND_RESET) begin
          found_d    = 5'd0;
          ovf_d      = 8'd0;
          err_d      = 8'd0;
          finish_d   = 32'd0;
          deadline_d = 32'd0;
          addr_d     = 7'd0;
        end
      end
      isc_pkg::KIND_CONSUME: begin
      end
      default: begin
      end
    endcase
    changed_out = changed_d;
    if (item_i.kind == isc_pkg::KIND_CONSUME) begin
      changed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= isc_pkg::PH_IDLE;
      deadline_q <= 32'd0;
      addr_q     <= 7'd0;
      found_q    <= 5'd0;
      ovf_q      <= 8'd0;
      err_q      <= 8'd0;
      changed_q  <= 1'b0;
      finish_q   <= 32'd0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      deadline_q <= deadline_d;
      addr_q     <= addr_d;
      found_q    <= found_d;
      ovf_q      <= ovf_d;
      err_q      <= err_d;
      changed_q  <= changed_d;
      finish_q   <= finish_d;
    end
  end

  always_comb begin
    res_o.scan_state     = phase_d;
    res_o.accepted       = accepted;
    res_o.scan_address   = addr_d;
    res_o.device_count   = found_d;
    res_o.overflow_count = ovf_d;
    res_o.error_count    = err_d;
    res_o.changed        = changed_out;
    res_o.power_on       = pwr;
    res_o.bus_release    = release_req;
    res_o.found_valid    = fvalid;
    res_o.found_address  = faddr;
    res_o.last_scan_ms   = finish_d;
  end

endmodule

[rtl/core/isc_out_stage.sv]
// ----------------------------------------------------------------------------
// isc_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module isc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  isc_pkg::out_word_t res_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output isc_pkg::out_word_t out_data_o
);

  logic               vld_d, vld_q;
  isc_pkg::out_word_t data_q;

  // a new word may enter when empty or when the held one leaves now
  assign room_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q && out_stall_i;
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/i2c_address_scan_sequencer_core.sv]
// ----------------------------------------------------------------------------
// i2c_address_scan_sequencer_core
// Event-driven i2c bus address scan sequencer with a plain config port.
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel while in_stall_o is low, and
// returns exactly one result word per input word, in order. A word passes an
// input register, the single-pass sequencer update and a result register,
// from which its result is presented; the block keeps one word per cycle
// flowing as long as the receiver does not stall. Configuration registers
// (power delay, settle delay, first and last address) are written through
// cfg_we_i with cfg_idx_i selecting the register; write them only while no
// word is in flight.
module i2c_address_scan_sequencer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  isc_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output isc_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  isc_pkg::cfg_t      cfg_q;
  logic               item_vld;
  isc_pkg::in_word_t  item;
  logic               room;
  logic               take;
  isc_pkg::out_word_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_delay_ms  <= isc_pkg::PowerDelayRst;
      cfg_q.settle_delay_ms <= isc_pkg::SettleDelayRst;
      cfg_q.first_address   <= isc_pkg::FirstAddrRst;
      cfg_q.last_address    <= isc_pkg::LastAddrRst;
    end else if (cfg_we_i) begin
      unique case (isc_pkg::reg_idx_e'(cfg_idx_i))
        isc_pkg::REG_POWER_DELAY:  cfg_q.power_delay_ms  <= cfg_wdata_i;
        isc_pkg::REG_SETTLE_DELAY: cfg_q.settle_delay_ms <= cfg_wdata_i;
        isc_pkg::REG_FIRST_ADDR:   cfg_q.first_address   <= cfg_wdata_i[6:0];
        isc_pkg::REG_LAST_ADDR:    cfg_q.last_address    <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  assign take = item_vld && room;

  isc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .vld_o      (item_vld),
    .data_o     (item)
  );

  isc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  isc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[dv/i2c_address_scan_sequencer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_address_scan_sequencer_core_tb
// Self-checking bench for the address scan sequencer. A short table of
// directed words is followed by randomized scans under several register
// settings. Each accepted word is run through a local sequencer model and
// every result word is compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module i2c_address_scan_sequencer_core_tb;

  localparam logic [2:0]  KindSpareLo   = 3'd5;
  localparam logic [2:0]  KindSpareHi   = 3'd7;
  localparam int unsigned PhaseBudget   = 175;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 64;

  typedef struct packed {
    isc_pkg::in_word_t  word;
    logic               typed;
    isc_pkg::out_word_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  isc_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  isc_pkg::out_word_t out_word;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [15:0]        cfg_wdata;

  // local sequencer model
  isc_pkg::cfg_t   scan_cfg;
  isc_pkg::phase_e seq_phase;
  logic [31:0]     seq_deadline;
  logic [6:0]      seq_addr;
  logic [4:0]      seq_found;
  logic [7:0]      seq_overflow;
  logic [7:0]      seq_errors;
  logic            seq_changed;
  logic [31:0]     seq_finish_ms;

  isc_pkg::out_word_t scan_results_due[$];
  dir_row_t           directed_rows[$];
  int unsigned        failures = 0;
  int unsigned        phase_items;
  logic [31:0]        wall_ms = 32'h0;
  bit                 in_idle = 1'b1;
  bit                 out_idle = 1'b1;
  bit                 hold_off_req = 1'b0;

  always #5 clk = ~clk;

  i2c_address_scan_sequencer_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_status();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic deadline_passed(logic [31:0] now);
    logic [31:0] diff;
    diff = now - seq_deadline;
    return ~diff[31];
  endfunction

  function automatic logic seq_busy();
    return seq_phase == isc_pkg::PH_POWERING || seq_phase == isc_pkg::PH_SETTLING ||
           seq_phase == isc_pkg::PH_SCANNING;
  endfunction

  function automatic void clear_counts();
    seq_found    = '0;
    seq_overflow = '0;
    seq_errors   = '0;
  endfunction

  function automatic isc_pkg::out_word_t sequencer_next(isc_pkg::in_word_t w);
    isc_pkg::out_word_t r;
    logic [6:0]         span;
    r = '0;
    case (w.kind)
      isc_pkg::KIND_TICK: begin
        if (seq_phase == isc_pkg::PH_POWERING && deadline_passed(w.now_ms)) begin
          if (!w.bus_ready) begin
            r.bus_release = 1'b1;
            seq_phase = isc_pkg::PH_ERROR;
          end else begin
            seq_deadline = w.now_ms + {16'h0, scan_cfg.settle_delay_ms};
            seq_phase = isc_pkg::PH_SETTLING;
          end
          seq_changed = 1'b1;
        end else if (seq_phase == isc_pkg::PH_SETTLING && deadline_passed(w.now_ms)) begin
          seq_phase = isc_pkg::PH_SCANNING;
          seq_changed = 1'b1;
        end else if (seq_phase == isc_pkg::PH_SCANNING) begin
          if (w.probe_status == isc_pkg::ProbeAck) begin
            if (seq_found < isc_pkg::TableDepth) begin
              seq_found++;
              r.found_valid   = 1'b1;
              r.found_address = seq_addr;
            end else if (seq_overflow != isc_pkg::CountMax) begin
              seq_overflow++;
            end
            seq_changed = 1'b1;
          end else if (w.probe_status != isc_pkg::ProbeNack) begin
            if (seq_errors != isc_pkg::CountMax) seq_errors++;
            seq_changed = 1'b1;
          end
          if (seq_addr >= scan_cfg.last_address) begin
            r.bus_release = 1'b1;
            seq_finish_ms = w.now_ms;
            seq_phase = isc_pkg::PH_SCANNED;
            seq_changed = 1'b1;
          end else begin
            seq_addr = seq_addr + 7'd1;
            // progress mark every few addresses from the first one
            span = seq_addr - scan_cfg.first_address;
            if (span % isc_pkg::ProgressStep == 0) seq_changed = 1'b1;
          end
        end
      end
      isc_pkg::KIND_START: begin
        if (!seq_busy()) begin
          clear_counts();
          seq_addr     = scan_cfg.first_address;
          seq_deadline = w.now_ms + {16'h0, scan_cfg.power_delay_ms};
          seq_phase    = isc_pkg::PH_POWERING;
          seq_changed  = 1'b1;
          r.power_on   = 1'b1;
          r.accepted   = 1'b1;
        end
      end
      isc_pkg::KIND_STOP, isc_pkg::KIND_RESET: begin
        if (seq_busy()) r.bus_release = 1'b1;
        seq_phase = isc_pkg::PH_IDLE;
        seq_changed = 1'b1;
        if (w.kind == isc_pkg::KIND_RESET) begin
          clear_counts();
          seq_finish_ms = '0;
          seq_deadline  = '0;
          seq_addr      = '0;
        end
      end
      default: ;
    endcase
    r.changed = seq_changed;
    if (w.kind == isc_pkg::KIND_CONSUME) seq_changed = 1'b0;
    r.scan_state     = seq_phase;
    r.scan_address   = seq_addr;
    r.device_count   = seq_found;
    r.overflow_count = seq_overflow;
    r.error_count    = seq_errors;
    r.last_scan_ms   = seq_finish_ms;
    return r;
  endfunction

  function automatic isc_pkg::in_word_t word_of(logic [2:0] kind, logic [31:0] now,
                                                logic ready, logic [7:0] status);
    isc_pkg::in_word_t w;
    w.kind         = kind;
    w.now_ms       = now;
    w.bus_ready    = ready;
    w.probe_status = status;
    return w;
  endfunction

  function automatic isc_pkg::out_word_t want_of(isc_pkg::phase_e st, logic acc,
                                                 logic [6:0] addr, logic chg,
                                                 logic pwr, logic rel);
    isc_pkg::out_word_t r;
    r = '0;
    r.scan_state   = st;
    r.accepted     = acc;
    r.scan_address = addr;
    r.changed      = chg;
    r.power_on     = pwr;
    r.bus_release  = rel;
    return r;
  endfunction

  function automatic logic [7:0] probe_draw(int unsigned ack_pct, int unsigned err_pct);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < ack_pct) return isc_pkg::ProbeAck;
    if (p < ack_pct + err_pct) return rand_status();
    return isc_pkg::ProbeNack;
  endfunction

  task automatic add_row(isc_pkg::in_word_t w, logic typed, isc_pkg::out_word_t want);
    dir_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge with valid still up
  task automatic send_word(isc_pkg::in_word_t w, int unsigned gap, logic typed,
                           isc_pkg::out_word_t want);
    isc_pkg::out_word_t due;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    due = sequencer_next(w);
    scan_results_due.push_back(typed ? want : due);
    @(negedge clk);
  endtask

  task automatic put(isc_pkg::in_word_t w);
    send_word(w, in_idle ? $urandom_range(0, 11) : 0, 1'b0, '0);
    if (w.kind <= isc_pkg::KIND_CONSUME) phase_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(isc_pkg::cfg_t c);
    cfg_we    <= 1'b1;
    cfg_idx   <= isc_pkg::REG_POWER_DELAY;
    cfg_wdata <= c.power_delay_ms;
    @(negedge clk);
    cfg_idx   <= isc_pkg::REG_SETTLE_DELAY;
    cfg_wdata <= c.settle_delay_ms;
    @(negedge clk);
    cfg_idx   <= isc_pkg::REG_FIRST_ADDR;
    cfg_wdata <= {9'h0, c.first_address};
    @(negedge clk);
    cfg_idx   <= isc_pkg::REG_LAST_ADDR;
    cfg_wdata <= {9'h0, c.last_address};
    @(negedge clk);
    cfg_we <= 1'b0;
    scan_cfg = c;
  endtask

  // one start-to-finish scan with some noise mixed in
  task automatic run_scan(int unsigned ack_pct, int unsigned err_pct);
    int unsigned r;
    if ($urandom_range(0, 7) == 0) wall_ms = $urandom();
    else wall_ms += $urandom_range(0, 5000);
    put(word_of(isc_pkg::KIND_START, wall_ms, rand_bit(), rand_status()));
    if ($urandom_range(0, 9) == 0)
      put(word_of(isc_pkg::KIND_START, wall_ms + 32'd1, rand_bit(), rand_status()));
    // ticks that come too early
    repeat ($urandom_range(0, 2))
      put(word_of(isc_pkg::KIND_TICK, seq_deadline - 32'd1 - $urandom_range(0, 2000),
                  rand_bit(), rand_status()));
    wall_ms = seq_deadline + $urandom_range(0, 3);
    put(word_of(isc_pkg::KIND_TICK, wall_ms, $urandom_range(0, 9) != 0, rand_status()));
    if (seq_phase == isc_pkg::PH_SETTLING) begin
      repeat ($urandom_range(0, 2))
        put(word_of(isc_pkg::KIND_TICK, seq_deadline - 32'd1 - $urandom_range(0, 2000),
                    rand_bit(), rand_status()));
      wall_ms = seq_deadline + $urandom_range(0, 3);
      put(word_of(isc_pkg::KIND_TICK, wall_ms, rand_bit(), rand_status()));
    end
    while (seq_phase == isc_pkg::PH_SCANNING) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        put(word_of(isc_pkg::KIND_CONSUME, $urandom(), rand_bit(), rand_status()));
      end else if (r < 4) begin
        put(word_of(3'($urandom_range(KindSpareLo, KindSpareHi)), $urandom(),
                    rand_bit(), rand_status()));
      end else if (r < 5) begin
        put(word_of(isc_pkg::KIND_START, $urandom(), rand_bit(), rand_status()));
      end else if (r == 5 && $urandom_range(0, 3) == 0) begin
        put(word_of($urandom_range(0, 1) ? isc_pkg::KIND_STOP : isc_pkg::KIND_RESET,
                    $urandom(), rand_bit(), rand_status()));
      end else begin
        wall_ms += $urandom_range(0, 5);
        put(word_of(isc_pkg::KIND_TICK, wall_ms, rand_bit(), probe_draw(ack_pct, err_pct)));
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    isc_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_results_due.size() == 0) begin
        $display("%0t result word: expected none, got %h", $time, out_word);
        failures++;
      end else begin
        want = scan_results_due.pop_front();
        check_field("scan_state", 32'(want.scan_state), 32'(out_word.scan_state));
        check_field("accepted", 32'(want.accepted), 32'(out_word.accepted));
        check_field("scan_address", 32'(want.scan_address), 32'(out_word.scan_address));
        check_field("device_count", 32'(want.device_count), 32'(out_word.device_count));
        check_field("overflow_count", 32'(want.overflow_count),
                    32'(out_word.overflow_count));
        check_field("error_count", 32'(want.error_count), 32'(out_word.error_count));
        check_field("changed", 32'(want.changed), 32'(out_word.changed));
        check_field("power_on", 32'(want.power_on), 32'(out_word.power_on));
        check_field("bus_release", 32'(want.bus_release), 32'(out_word.bus_release));
        check_field("found_valid", 32'(want.found_valid), 32'(out_word.found_valid));
        check_field("found_address", 32'(want.found_address),
                    32'(out_word.found_address));
        check_field("last_scan_ms", want.last_scan_ms, out_word.last_scan_ms);
      end
    end
  end

  // receiver: random stall per word, one long hold-off on request
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold = HoldOffCycles;
        hold_off_req = 1'b0;
      end else if (out_idle) begin
        hold = $urandom_range(0, 11);
      end else begin
        hold = 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    isc_pkg::cfg_t c;
    int unsigned   ack_pct;
    int unsigned   err_pct;
    int unsigned   scans;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = isc_pkg::REG_POWER_DELAY;
    cfg_wdata = '0;
    scan_cfg  = {isc_pkg::PowerDelayRst, isc_pkg::SettleDelayRst, isc_pkg::FirstAddrRst,
                 isc_pkg::LastAddrRst};
    seq_phase     = isc_pkg::PH_IDLE;
    seq_deadline  = '0;
    seq_addr      = '0;
    seq_changed   = 1'b0;
    seq_finish_ms = '0;
    clear_counts();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words on the reset register values
    add_row(word_of(isc_pkg::KIND_CONSUME, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b1, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'hFFFF_FFFF, 1'b1, 8'hFF), 1'b1, '0);
    add_row(word_of(KindSpareHi, 32'hFFFF_FFFF, 1'b1, 8'hFF), 1'b1, '0);
    add_row(word_of(isc_pkg::KIND_START, 32'h0, 1'b0, isc_pkg::ProbeNack), 1'b1,
            want_of(isc_pkg::PH_POWERING, 1'b1, isc_pkg::FirstAddrRst, 1'b1, 1'b1, 1'b0));
    add_row(word_of(isc_pkg::KIND_START, 32'd5, 1'b1, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'd99, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'd100, 1'b0, isc_pkg::ProbeAck), 1'b1,
            want_of(isc_pkg::PH_ERROR, 1'b0, isc_pkg::FirstAddrRst, 1'b1, 1'b0, 1'b1));
    // start from error just before the time wraps
    add_row(word_of(isc_pkg::KIND_START, 32'hFFFF_FFC0, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h23, 1'b1, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h24, 1'b1, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h37, 1'b1, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h38, 1'b1, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h39, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h3A, 1'b0, isc_pkg::ProbeNack), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h3B, 1'b0, 8'hFF), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_TICK, 32'h3C, 1'b0, 8'h01), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_CONSUME, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_CONSUME, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_STOP, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_STOP, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_START, 32'h1000, 1'b1, isc_pkg::ProbeAck), 1'b0, '0);
    add_row(word_of(isc_pkg::KIND_RESET, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b1,
            want_of(isc_pkg::PH_IDLE, 1'b0, 7'h0, 1'b1, 1'b0, 1'b1));
    add_row(word_of(KindSpareLo, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b1,
            want_of(isc_pkg::PH_IDLE, 1'b0, 7'h0, 1'b1, 1'b0, 1'b0));
    add_row(word_of(isc_pkg::KIND_CONSUME, 32'h0, 1'b0, isc_pkg::ProbeAck), 1'b0, '0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, $urandom_range(0, 11), directed_rows[i].typed,
                directed_rows[i].want);
    drain();

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      ack_pct = 30;
      err_pct = 15;
      case (ph)
        0: begin
          c = {isc_pkg::PowerDelayRst, isc_pkg::SettleDelayRst, isc_pkg::FirstAddrRst,
               isc_pkg::LastAddrRst};
        end
        1: begin
          // whole address range, mostly acks so the table overflows
          c = {16'h0, 16'h0, 7'h00, 7'h7F};
          ack_pct = 85;
          err_pct = 5;
        end
        2: begin
          c = {16'hFFFF, 16'hFFFF, 7'h7F, 7'h00};
          err_pct = 30;
        end
        3: begin
          c = {16'hFFFF, 16'h0, 7'h7F, 7'h7F};
        end
        default: begin
          c.power_delay_ms  = 16'($urandom_range(0, 400));
          c.settle_delay_ms = 16'($urandom_range(0, 400));
          c.first_address   = 7'($urandom_range(0, 127));
          if ($urandom_range(0, 9) == 0)
            c.last_address = 7'($urandom_range(0, 127));
          else if (c.first_address + 30 > 127)
            c.last_address = 7'h7F;
          else
            c.last_address = 7'(c.first_address + $urandom_range(0, 30));
          ack_pct = $urandom_range(10, 80);
          err_pct = $urandom_range(0, 20);
        end
      endcase
      set_config(c);
      phase_items = 0;
      scans = 0;
      while (phase_items < PhaseBudget) begin
        in_idle  = $urandom_range(0, 3) != 0;
        out_idle = $urandom_range(0, 3) != 0;
        if (ph == 1 && scans == 0) begin
          // keep offering words while the receiver holds off
          in_idle = 1'b0;
          hold_off_req = 1'b1;
        end
        repeat ($urandom_range(0, 2))
          put(word_of(3'($urandom_range(isc_pkg::KIND_TICK, KindSpareHi)), $urandom(),
                      rand_bit(), rand_status()));
        run_scan(ack_pct, err_pct);
        if ($urandom_range(0, 1))
          put(word_of(isc_pkg::KIND_CONSUME, $urandom(), rand_bit(), rand_status()));
        scans++;
      end
      drain();
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
